// ----- design/wdgd_pkg.sv -----
// ----------------------------------------------------------------------------
// wdgd_pkg
// Shared types and constants for the wrapped diamond-grid distance pipeline.
// ----------------------------------------------------------------------------
package wdgd_pkg;

    localparam int COL_LIMIT = 256;
    localparam int ROW_LIMIT = 256;

    // Register and operand widths.
    localparam int CNT_W  = 9;   // column_count / row_count
    localparam int SPAN_W = 10;  // 2 * column count
    localparam int MV_W   = 12;  // modulo dividend, up to 2*511+255
    localparam int DV_W   = 10;  // modulo divisor and remainder

    // The restoring modulo walks the quotient bits MV_W-2 down to 0.
    localparam int MOD_K_HI  = MV_W - 2;
    localparam int MOD_K1_HI = 6;
    localparam int MOD_K2_HI = 2;

    // Configuration register indexes.
    localparam logic REG_COLUMN_COUNT = 1'b0;
    localparam logic REG_ROW_COUNT    = 1'b1;

    typedef enum logic [1:0] {
        ACT_XY_DIST  = 2'd0,
        ACT_RC_DIST  = 2'd1,
        ACT_XY_TO_RC = 2'd2,
        ACT_RC_TO_XY = 2'd3
    } t_action;

    typedef struct packed {
        t_action     action;
        logic [8:0]  a_x;
        logic [7:0]  a_y;
        logic [8:0]  b_x;
        logic [7:0]  b_y;
    } t_in_item;

    typedef struct packed {
        logic [8:0]  step_distance;
        logic [16:0] squared_quarters;
        logic [7:0]  rounded_distance;
        logic [8:0]  converted_x;
        logic [7:0]  converted_y;
    } t_out_item;

endpackage

// ----- design/wdgd_modpipe.sv -----
// ----------------------------------------------------------------------------
// wdgd_modpipe
// Three-stage restoring modulo: remainder of a value by a run-time divisor.
// ----------------------------------------------------------------------------
module wdgd_modpipe (
    input  logic                        i_clk,
    input  logic [2:0]                  i_en,
    input  logic [wdgd_pkg::MV_W-1:0]   i_value,
    input  logic [wdgd_pkg::DV_W-1:0]   i_divisor,
    output logic [wdgd_pkg::DV_W-1:0]   o_rem
);
    import wdgd_pkg::*;

    localparam int SH_W = MV_W + DV_W;

    logic [MV_W-1:0] r_v1, r_v2, r_v3;
    logic [DV_W-1:0] r_d1, r_d2;
    logic [MV_W-1:0] n_v1, n_v2, n_v3;

    // Each stage tries to subtract the divisor shifted by a few quotient bits.
    always_comb begin
        logic [SH_W-1:0] sh;
        n_v1 = i_value;
        for (int k = MOD_K_HI; k > MOD_K1_HI; k--) begin
            sh = {{(SH_W-DV_W){1'b0}}, i_divisor} << k;
            if ({{DV_W{1'b0}}, n_v1} >= sh) begin
                n_v1 = n_v1 - sh[MV_W-1:0];
            end
        end
        n_v2 = r_v1;
        for (int k = MOD_K1_HI; k > MOD_K2_HI; k--) begin
            sh = {{(SH_W-DV_W){1'b0}}, r_d1} << k;
            if ({{DV_W{1'b0}}, n_v2} >= sh) begin
                n_v2 = n_v2 - sh[MV_W-1:0];
            end
        end
        n_v3 = r_v2;
        for (int k = MOD_K2_HI; k >= 0; k--) begin
            sh = {{(SH_W-DV_W){1'b0}}, r_d2} << k;
            if ({{DV_W{1'b0}}, n_v3} >= sh) begin
                n_v3 = n_v3 - sh[MV_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_v1 <= n_v1;
            r_d1 <= i_divisor;
        end
        if (i_en[1]) begin
            r_v2 <= n_v2;
            r_d2 <= r_d1;
        end
        if (i_en[2]) begin
            r_v3 <= n_v3;
        end
    end

    assign o_rem = r_v3[DV_W-1:0];

endmodule

// ----- design/wrapped_diamond_grid_distance.sv -----
// ----------------------------------------------------------------------------
// wrapped_diamond_grid_distance
// Wrapped diamond-grid travel, squared and rounded distance, and XY/RC
// conversion of a point, as an eleven-stage pipeline.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; stages that hold no item fill while the
// output is stalled, so a stall backs up only through occupied stages.
// Depth is set by the three-stage modulo unit and the three-stage square root.
// Reset clears all valid bits and sets both counts to 256.
module wrapped_diamond_grid_distance (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  wdgd_pkg::t_in_item     i_item,
    output logic                   o_valid,
    input  logic                   i_stall,
    output wdgd_pkg::t_out_item    o_item,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic                   i_cfg_index,
    input  logic [8:0]             i_cfg_data
);
    import wdgd_pkg::*;

    localparam int NST = 10;

    typedef struct packed {
        logic [17:0] bits;
        logic [10:0] rem;
        logic [8:0]  root;
    } t_sq;

    // Three digit steps of the bitwise integer square root.
    function automatic t_sq sq_step3(input t_sq s_in);
        t_sq         s;
        logic [12:0] rem2;
        logic [12:0] trial;
        logic [12:0] diff;
        s = s_in;
        for (int i = 0; i < 3; i++) begin
            rem2   = {s.rem, s.bits[17:16]};
            s.bits = {s.bits[15:0], 2'b00};
            trial  = {2'b00, s.root, 2'b01};
            diff   = rem2 - trial;
            if (rem2 >= trial) begin
                s.rem  = diff[10:0];
                s.root = {s.root[7:0], 1'b1};
            end else begin
                s.rem  = rem2[10:0];
                s.root = {s.root[7:0], 1'b0};
            end
        end
        return s;
    endfunction

    // Configuration.
    logic [CNT_W-1:0]  r_col_eff, r_row_eff;
    logic [SPAN_W-1:0] r_xspan;
    logic [CNT_W-1:0]  n_cfg_eff;
    logic [CNT_W-1:0]  n_cfg_lim;

    // Pipeline control.
    logic [NST-1:0] r_v;
    logic           r_ov;
    logic [NST-1:0] en;
    logic           en_out;

    // Side data travelling with the item.
    t_action     r_act  [0:NST-1];
    logic [7:0]  r_ay   [0:NST-1];
    logic        r_neg  [0:3];
    logic [8:0]  r_conv [4:NST-1];
    logic [8:0]  r_trip [5:NST-1];
    logic [16:0] r_t    [6:NST-1];
    t_sq         r_sq   [7:NST-1];

    // Stage 0 operands.
    logic [MV_W-1:0] r_xa_val, r_xb_val, r_ya_val, r_yb_val;
    logic [DV_W-1:0] r_xa_div;
    logic [MV_W-1:0] n_xa_val, n_xb_val;
    logic [DV_W-1:0] n_xa_div;
    logic            n_neg;
    logic [9:0]      diff_pos, diff_neg;
    logic [7:0]      mag;
    logic [MV_W-1:0] lin_a, lin_b;

    // Remainders from the modulo units.
    logic [DV_W-1:0] rem_xa, rem_xb, rem_ya, rem_yb;

    // Stage 4 to 6.
    logic [9:0]  r_dxu, r_dxw;
    logic [8:0]  r_dyu, r_dyw;
    logic [19:0] r_sqxu, r_sqxw;
    logic [17:0] r_sqyu, r_sqyw;
    logic [9:0]  n_dxu, n_dxw, n_col;
    logic [8:0]  n_dyu, n_dyw, n_conv;
    logic [9:0]  n_sx, n_sy, n_lo, n_hi, n_trip, n_half;
    logic [20:0] s1, s2, s3, s4, m12, m34, n_tmin;
    t_sq         n_sq_init;
    logic [9:0]  n_round;
    t_out_item   r_out;

    // ---------------- configuration ----------------
    always_comb begin
        n_cfg_lim = (i_cfg_index == REG_COLUMN_COUNT) ? CNT_W'(COL_LIMIT)
                                                      : CNT_W'(ROW_LIMIT);
        if (i_cfg_data == '0) begin
            n_cfg_eff = CNT_W'(1);
        end else if (i_cfg_data > n_cfg_lim) begin
            n_cfg_eff = n_cfg_lim;
        end else begin
            n_cfg_eff = i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_eff <= CNT_W'(COL_LIMIT);
            r_row_eff <= CNT_W'(ROW_LIMIT);
            r_xspan   <= SPAN_W'(2 * COL_LIMIT);
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_COLUMN_COUNT) begin
                r_col_eff <= n_cfg_eff;
                r_xspan   <= {n_cfg_eff, 1'b0};
            end else begin
                r_row_eff <= n_cfg_eff;
            end
        end
    end

    // ---------------- flow control ----------------
    // A stage takes a new item when it is empty or its item moves on.
    always_comb begin
        en_out      = !r_ov || !i_stall;
        en[NST-1]   = !r_v[NST-1] || en_out;
        for (int k = NST - 2; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_stall = !en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NST; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
            if (en_out) begin
                r_ov <= r_v[NST-1];
            end
        end
    end

    // ---------------- stage 0: operands ----------------
    always_comb begin
        diff_pos = {1'b0, i_item.a_x} - {2'b00, i_item.a_y};
        diff_neg = {2'b00, i_item.a_y} - {1'b0, i_item.a_x};
        n_neg    = {1'b0, i_item.a_y} > i_item.a_x;
        // Halving truncates toward zero, so the magnitude is halved.
        mag      = n_neg ? diff_neg[8:1] : diff_pos[8:1];
        lin_a    = {2'b00, i_item.a_x, 1'b0} + {4'b0000, i_item.a_y};
        lin_b    = {2'b00, i_item.b_x, 1'b0} + {4'b0000, i_item.b_y};
        case (i_item.action)
            ACT_RC_DIST, ACT_RC_TO_XY: begin
                n_xa_val = lin_a;
                n_xa_div = r_xspan;
            end
            ACT_XY_TO_RC: begin
                n_xa_val = {{(MV_W-8){1'b0}}, mag};
                n_xa_div = {1'b0, r_col_eff};
            end
            default: begin
                n_xa_val = {{(MV_W-9){1'b0}}, i_item.a_x};
                n_xa_div = r_xspan;
            end
        endcase
        n_xb_val = (i_item.action == ACT_RC_DIST) ? lin_b
                                                  : {{(MV_W-9){1'b0}}, i_item.b_x};
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_xa_val <= n_xa_val;
            r_xa_div <= n_xa_div;
            r_xb_val <= n_xb_val;
            r_ya_val <= {{(MV_W-8){1'b0}}, i_item.a_y};
            r_yb_val <= {{(MV_W-8){1'b0}}, i_item.b_y};
            r_neg[0] <= n_neg;
            r_act[0] <= i_item.action;
            r_ay[0]  <= i_item.a_y;
        end
        for (int k = 1; k < NST; k++) begin
            if (en[k]) begin
                r_act[k] <= r_act[k-1];
                r_ay[k]  <= r_ay[k-1];
            end
        end
        for (int k = 1; k < 4; k++) begin
            if (en[k]) begin
                r_neg[k] <= r_neg[k-1];
            end
        end
    end

    // ---------------- stages 1-3: wrap by modulo ----------------
    wdgd_modpipe u_mod_xa (
        .i_clk     (i_clk),
        .i_en      (en[3:1]),
        .i_value   (r_xa_val),
        .i_divisor (r_xa_div),
        .o_rem     (rem_xa)
    );

    wdgd_modpipe u_mod_xb (
        .i_clk     (i_clk),
        .i_en      (en[3:1]),
        .i_value   (r_xb_val),
        .i_divisor (r_xspan),
        .o_rem     (rem_xb)
    );

    wdgd_modpipe u_mod_ya (
        .i_clk     (i_clk),
        .i_en      (en[3:1]),
        .i_value   (r_ya_val),
        .i_divisor ({1'b0, r_row_eff}),
        .o_rem     (rem_ya)
    );

    wdgd_modpipe u_mod_yb (
        .i_clk     (i_clk),
        .i_en      (en[3:1]),
        .i_value   (r_yb_val),
        .i_divisor ({1'b0, r_row_eff}),
        .o_rem     (rem_yb)
    );

    // ---------------- stage 4: deltas and conversion ----------------
    always_comb begin
        // A negative quotient wraps to the column count minus its remainder.
        n_col = (r_neg[3] && rem_xa != '0) ? ({1'b0, r_col_eff} - rem_xa) : rem_xa;
        case (r_act[3])
            ACT_XY_TO_RC: n_conv = n_col[8:0];
            ACT_RC_TO_XY: n_conv = rem_xa[8:0];
            default:      n_conv = '0;
        endcase
        n_dxu = (rem_xa > rem_xb) ? (rem_xa - rem_xb) : (rem_xb - rem_xa);
        n_dxw = r_xspan - n_dxu;
        n_dyu = (rem_ya > rem_yb) ? (rem_ya[8:0] - rem_yb[8:0])
                                  : (rem_yb[8:0] - rem_ya[8:0]);
        n_dyw = r_row_eff - n_dyu;
    end

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_dxu     <= n_dxu;
            r_dxw     <= n_dxw;
            r_dyu     <= n_dyu;
            r_dyw     <= n_dyw;
            r_conv[4] <= n_conv;
        end
        for (int k = 5; k < NST; k++) begin
            if (en[k]) begin
                r_conv[k] <= r_conv[k-1];
            end
        end
    end

    // ---------------- stage 5: squares and travel ----------------
    always_comb begin
        n_sx   = (r_dxu < r_dxw) ? r_dxu : r_dxw;
        n_sy   = {1'b0, (r_dyu < r_dyw) ? r_dyu : r_dyw};
        n_lo   = (n_sx < n_sy) ? n_sx : n_sy;
        n_hi   = (n_sx < n_sy) ? n_sy : n_sx;
        n_half = (n_hi - n_lo) >> 1;
        n_trip = n_lo + n_half;
    end

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_sqxu    <= {10'b0, r_dxu} * {10'b0, r_dxu};
            r_sqxw    <= {10'b0, r_dxw} * {10'b0, r_dxw};
            r_sqyu    <= {9'b0, r_dyu} * {9'b0, r_dyu};
            r_sqyw    <= {9'b0, r_dyw} * {9'b0, r_dyw};
            r_trip[5] <= n_trip[8:0];
        end
        for (int k = 6; k < NST; k++) begin
            if (en[k]) begin
                r_trip[k] <= r_trip[k-1];
            end
        end
    end

    // ---------------- stage 6: least of the four wrap combinations ----------------
    always_comb begin
        s1     = {1'b0, r_sqxu} + {3'b000, r_sqyu};
        s2     = {1'b0, r_sqxw} + {3'b000, r_sqyu};
        s3     = {1'b0, r_sqxu} + {3'b000, r_sqyw};
        s4     = {1'b0, r_sqxw} + {3'b000, r_sqyw};
        m12    = (s1 < s2) ? s1 : s2;
        m34    = (s3 < s4) ? s3 : s4;
        n_tmin = (m12 < m34) ? m12 : m34;
    end

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r_t[6] <= n_tmin[16:0];
        end
        for (int k = 7; k < NST; k++) begin
            if (en[k]) begin
                r_t[k] <= r_t[k-1];
            end
        end
    end

    // ---------------- stages 7-9: square root ----------------
    always_comb begin
        n_sq_init.bits = {1'b0, r_t[6]};
        n_sq_init.rem  = '0;
        n_sq_init.root = '0;
    end

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r_sq[7] <= sq_step3(n_sq_init);
        end
        for (int k = 8; k < NST; k++) begin
            if (en[k]) begin
                r_sq[k] <= sq_step3(r_sq[k-1]);
            end
        end
    end

    // ---------------- output register ----------------
    assign n_round = {1'b0, r_sq[NST-1].root} + 10'd1;

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            if (r_act[NST-1] == ACT_XY_TO_RC || r_act[NST-1] == ACT_RC_TO_XY) begin
                r_out.step_distance    <= '0;
                r_out.squared_quarters <= '0;
                r_out.rounded_distance <= '0;
                r_out.converted_x      <= r_conv[NST-1];
                r_out.converted_y      <= r_ay[NST-1];
            end else begin
                r_out.step_distance    <= r_trip[NST-1];
                r_out.squared_quarters <= r_t[NST-1];
                r_out.rounded_distance <= n_round[8:1];
                r_out.converted_x      <= '0;
                r_out.converted_y      <= '0;
            end
        end
    end

    assign o_valid = r_ov;
    assign o_item  = r_out;

endmodule

// ----- design/wdgd_checker.sv -----
// ----------------------------------------------------------------------------
// wdgd_checker
// Port-level checks on the wrapped diamond-grid distance pipeline.
// ----------------------------------------------------------------------------
module wdgd_checker (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic                   o_stall,
    input  wdgd_pkg::t_in_item     i_item,
    input  logic                   o_valid,
    input  logic                   i_stall,
    input  wdgd_pkg::t_out_item    o_item,
    input  logic                   i_cfg_valid,
    input  logic                   o_cfg_ready,
    input  logic                   i_cfg_index,
    input  logic [8:0]             i_cfg_data
);
    import wdgd_pkg::*;

    logic [17:0] rd2;
    logic [17:0] lo_sq, hi_sq;

    assign rd2   = {9'b0, o_item.rounded_distance, 1'b0};
    assign lo_sq = (rd2 - 18'd1) * (rd2 - 18'd1);
    assign hi_sq = (rd2 + 18'd1) * (rd2 + 18'd1);

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("stalled result changed");

    // Distance results and conversion results never mix.
    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_item.step_distance != '0 || o_item.squared_quarters != '0)
        |-> o_item.converted_x == '0 && o_item.converted_y == '0)
        else $error("conversion fields set on a distance result");

    // A nonzero travel distance has a nonzero squared distance.
    a_travel_sq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.step_distance != '0 |-> o_item.squared_quarters != '0)
        else $error("travel without squared distance");

    // The rounded distance brackets the squared quarter distance.
    a_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> {1'b0, o_item.squared_quarters} < hi_sq
                    && (o_item.rounded_distance == '0
                        || {1'b0, o_item.squared_quarters} >= lo_sq))
        else $error("rounded distance out of bracket");

endmodule

bind wrapped_diamond_grid_distance wdgd_checker u_wdgd_checker (.*);

// ----- dv/wrapped_diamond_grid_distance_test.sv -----
// ----------------------------------------------------------------------------
// wrapped_diamond_grid_distance_test
// Drives point pairs and conversions through the wrapped diamond-grid distance
// pipeline under several map sizes, predicts each result and checks it in order.
// ----------------------------------------------------------------------------
module wrapped_diamond_grid_distance_test;
    import wdgd_pkg::*;

    class distance_scoreboard;
        t_out_item pending[$];
        int        n_errors;
        int        n_checked;
        int        n_columns;
        int        n_rows;

        function new();
            n_errors  = 0;
            n_checked = 0;
            n_columns = 256;
            n_rows    = 256;
        endfunction

        function automatic longint isqrt(longint v);
            longint r;
            r = 0;
            while ((r + 1) * (r + 1) <= v) r++;
            return r;
        endfunction

        function automatic t_out_item predict(t_in_item it);
            t_out_item o;
            longint c, r, span, ax, ay, bx, by, col;
            longint dxu, dxw, dyu, dyw, sx, sy, lo, hi, t, s;
            o = '0;
            c = (n_columns < 1) ? 1 : (n_columns > COL_LIMIT ? COL_LIMIT : n_columns);
            r = (n_rows < 1) ? 1 : (n_rows > ROW_LIMIT ? ROW_LIMIT : n_rows);
            span = 2 * c;
            ax = longint'(it.a_x); ay = longint'(it.a_y);
            bx = longint'(it.b_x); by = longint'(it.b_y);
            case (it.action)
                ACT_XY_TO_RC: begin
                    col = ((ax - ay) / 2) % c;
                    if (col < 0) col += c;
                    o.converted_x = col[8:0];
                    o.converted_y = it.a_y;
                end
                ACT_RC_TO_XY: begin
                    col = (2 * ax + ay) % span;
                    o.converted_x = col[8:0];
                    o.converted_y = it.a_y;
                end
                default: begin
                    if (it.action == ACT_RC_DIST) begin
                        ax = (2 * ax + ay) % span;
                        bx = (2 * bx + by) % span;
                    end else begin
                        ax = ax % span;
                        bx = bx % span;
                    end
                    ay = ay % r;
                    by = by % r;
                    dxu = (ax > bx) ? ax - bx : bx - ax;
                    dxw = span - dxu;
                    dyu = (ay > by) ? ay - by : by - ay;
                    dyw = r - dyu;
                    sx = (dxu < dxw) ? dxu : dxw;
                    sy = (dyu < dyw) ? dyu : dyw;
                    lo = (sx < sy) ? sx : sy;
                    hi = (sx > sy) ? sx : sy;
                    // The squared sum is least when each axis takes its shorter delta.
                    t = sx * sx + sy * sy;
                    s = lo + (hi - lo) / 2;
                    o.step_distance    = s[8:0];
                    o.squared_quarters = t[16:0];
                    s = (isqrt(t) + 1) >> 1;
                    o.rounded_distance = s[7:0];
                end
            endcase
            return o;
        endfunction

        function void note_input(t_in_item it);
            pending.push_back(predict(it));
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (pending.size() == 0) begin
                report_mismatch("result with no item outstanding", 0, longint'(got));
                return;
            end
            want = pending.pop_front();
            n_checked++;
            if (got.step_distance != want.step_distance)
                report_mismatch("step_distance", longint'(want.step_distance),
                                longint'(got.step_distance));
            if (got.squared_quarters != want.squared_quarters)
                report_mismatch("squared_quarters", longint'(want.squared_quarters),
                                longint'(got.squared_quarters));
            if (got.rounded_distance != want.rounded_distance)
                report_mismatch("rounded_distance", longint'(want.rounded_distance),
                                longint'(got.rounded_distance));
            if (got.converted_x != want.converted_x)
                report_mismatch("converted_x", longint'(want.converted_x),
                                longint'(got.converted_x));
            if (got.converted_y != want.converted_y)
                report_mismatch("converted_y", longint'(want.converted_y),
                                longint'(got.converted_y));
        endfunction

        function void report_mismatch(string what, longint want, longint got);
            n_errors++;
            $display("MISMATCH result %0d %s: expected %0d got %0d",
                     n_checked, what, want, got);
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    t_in_item   in_item;
    logic       out_valid;
    logic       out_stall;
    t_out_item  out_item;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_index;
    logic [8:0] cfg_data;

    distance_scoreboard board;
    bit  quiet_tail;
    bit  hold_output;
    int  idle_cycles;
    int  n_sent;

    wrapped_diamond_grid_distance u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .o_stall     (in_stall),
        .i_item      (in_item),
        .o_valid     (out_valid),
        .i_stall     (out_stall),
        .o_item      (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Sampling at the rising edge: checks results and feeds the watchdog.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) board.check_result(out_item);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 5000) begin
                $display("timeout: no progress for %0d cycles", idle_cycles);
                $display("wrapped_diamond_grid_distance_test failed");
                $finish;
            end
        end
    end

    // Receiver stall, with random bursts unless the tail or a long hold is on.
    initial begin
        int n;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_output) begin
                out_stall = 1'b1;
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 16);
                out_stall = 1'b1;
                repeat (n - 1) @(negedge clk);
            end else begin
                out_stall = 1'b0;
            end
        end
    end

    task automatic send_item(t_in_item it);
        int n;
        if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 16);
            in_valid = 1'b0;
            repeat (n) @(negedge clk);
        end
        in_valid = 1'b1;
        in_item  = it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_input(it);
        n_sent++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic write_register(logic idx, logic [8:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == REG_COLUMN_COUNT) board.n_columns = int'(value);
        else board.n_rows = int'(value);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    function automatic t_in_item random_item(int c, int r);
        t_in_item it;
        it.action = t_action'($urandom_range(0, 3));
        // Mostly in-range coordinates, sometimes the full field width.
        if ($urandom_range(0, 3) == 0) begin
            it.a_x = 9'($urandom); it.a_y = 8'($urandom);
            it.b_x = 9'($urandom); it.b_y = 8'($urandom);
        end else begin
            it.a_x = 9'($urandom_range(0, 2 * c - 1 > 511 ? 511 : 2 * c - 1));
            it.b_x = 9'($urandom_range(0, 2 * c - 1 > 511 ? 511 : 2 * c - 1));
            it.a_y = 8'($urandom_range(0, r - 1 > 255 ? 255 : r - 1));
            it.b_y = 8'($urandom_range(0, r - 1 > 255 ? 255 : r - 1));
        end
        return it;
    endfunction

    task automatic run_phase(int c, int r, int count);
        t_in_item it;
        write_register(REG_COLUMN_COUNT, c[8:0]);
        write_register(REG_ROW_COUNT, r[8:0]);
        for (int i = 0; i < count; i++) begin
            it = random_item(c < 1 ? 1 : c, r < 1 ? 1 : r);
            send_item(it);
        end
        drain();
    endtask

    initial begin
        t_in_item it;
        board       = new();
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_item     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_COLUMN_COUNT;
        cfg_data    = '0;
        quiet_tail  = 1'b0;
        hold_output = 1'b0;
        idle_cycles = 0;
        n_sent      = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed items at reset sizes: field extremes and every action.
        for (int a = 0; a < 4; a++) begin
            it = '{t_action'(a), 9'd0, 8'd0, 9'd0, 8'd0};
            send_item(it);
            it = '{t_action'(a), 9'd511, 8'd255, 9'd0, 8'd0};
            send_item(it);
            it = '{t_action'(a), 9'd1, 8'd254, 9'd510, 8'd1};
            send_item(it);
            it = '{t_action'(a), 9'd256, 8'd128, 9'd255, 8'd127};
            send_item(it);
        end
        // Negative XY-to-RC columns that wrap, at reset sizes.
        it = '{ACT_XY_TO_RC, 9'd0, 8'd255, 9'd0, 8'd0};
        send_item(it);
        it = '{ACT_XY_TO_RC, 9'd3, 8'd200, 9'd0, 8'd0};
        send_item(it);
        drain();
        // A count of zero acts as one, and a count above the limit saturates.
        write_register(REG_COLUMN_COUNT, 9'd0);
        write_register(REG_ROW_COUNT, 9'd511);
        it = '{ACT_XY_DIST, 9'd511, 8'd255, 9'd3, 8'd17};
        send_item(it);
        it = '{ACT_RC_DIST, 9'd7, 8'd200, 9'd300, 8'd1};
        send_item(it);
        it = '{ACT_XY_TO_RC, 9'd5, 8'd77, 9'd0, 8'd0};
        send_item(it);
        drain();

        run_phase(1, 1, 60);
        run_phase(256, 256, 250);
        run_phase(7, 5, 120);

        // Long output hold while items keep coming, so the pipeline backs up.
        write_register(REG_COLUMN_COUNT, 9'd100);
        write_register(REG_ROW_COUNT, 9'd60);
        hold_output = 1'b1;
        fork
            begin
                repeat (60) begin
                    it = random_item(100, 60);
                    send_item(it);
                end
            end
            begin
                repeat (200) @(negedge clk);
                hold_output = 1'b0;
            end
        join
        drain();

        run_phase(300, 2, 120);
        quiet_tail = 1'b1;
        run_phase(33, 200, 120);

        $display("Sent %0d items over map sizes from 1x1 to saturated 256x256,", n_sent);
        $display("covering all four actions, wrap and a long output hold.");
        if (board.n_errors == 0 && board.pending.size() == 0)
            $display("wrapped_diamond_grid_distance_test passed");
        else
            $display("wrapped_diamond_grid_distance_test failed");
        $finish;
    end
endmodule
